// File: rtl/core/ldsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsm_pkg
// Shared widths, register indexes, reset values and types of the local
// deviation shadow mask block.
// ----------------------------------------------------------------------------
package ldsm_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned LUMA_W  = 8;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned LIMIT_W = 9;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_LIMIT = 2'd2;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 11'd480;
  localparam logic [LIMIT_W-1:0] RST_GLOBAL_LIMIT = 9'd0;

  // nine pixels: sum up to 9*255, sum of squares up to 9*255*255
  localparam int unsigned SUM_W = 12;
  localparam int unsigned SQ_W  = 20;
  // 81*y*y + sum*sum stays below 2^24
  localparam int unsigned CMP_W = 24;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq_sum;
    logic [LUMA_W-1:0] center;
    logic              below_limit;
    logic              frame_end;
  } ldsm_stat_t;

endpackage

// File: rtl/core/ldsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsm_if
// Valid/ready channels of the shadow mask block: pixel input, mask result
// and configuration write.
// ----------------------------------------------------------------------------
interface ldsm_pix_if;
  import ldsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] luma;
  logic              flush;
  modport source (output valid, luma, flush, input ready);
  modport sink   (input valid, luma, flush, output ready);
endinterface

interface ldsm_res_if;
  logic valid;
  logic ready;
  logic shadow;
  logic frame_end;
  modport source (output valid, shadow, frame_end, input ready);
  modport sink   (input valid, shadow, frame_end, output ready);
endinterface

interface ldsm_cfg_if;
  import ldsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ldsm_col_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsm_col_cell
// One column of the 3x3 window. Shifts a column in from its right neighbor
// and adds its masked pixel sum and sum of squares to the running totals.
// ----------------------------------------------------------------------------
module ldsm_col_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic [2:0][ldsm_pkg::LUMA_W-1:0]     col_i,
  output logic [2:0][ldsm_pkg::LUMA_W-1:0]     col_o,
  input  logic [2:0]                           row_en_i,
  input  logic                                 col_en_i,
  input  logic [ldsm_pkg::SUM_W-1:0]           sum_i,
  input  logic [ldsm_pkg::SQ_W-1:0]            sq_i,
  output logic [ldsm_pkg::SUM_W-1:0]           sum_o,
  output logic [ldsm_pkg::SQ_W-1:0]            sq_o
);
  import ldsm_pkg::*;

  logic [2:0][LUMA_W-1:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_i) begin
      pix_q <= col_i;
    end
  end

  assign col_o = pix_q;

  always_comb begin
    logic [SUM_W-1:0] s;
    logic [SQ_W-1:0]  q;
    s = sum_i;
    q = sq_i;
    for (int k = 0; k < 3; k++) begin
      if (col_en_i && row_en_i[k]) begin
        s = s + SUM_W'(pix_q[k]);
        q = q + SQ_W'(16'(pix_q[k]) * 16'(pix_q[k]));
      end
    end
    sum_o = s;
    sq_o  = q;
  end

endmodule

// File: rtl/core/ldsm_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsm_line_store
// Two line buffers packed into one word per column. Read at the accepted
// item's column, written back one stage later with the line moved up.
// ----------------------------------------------------------------------------
module ldsm_line_store #(
  parameter  int unsigned DEPTH  = ldsm_pkg::DEF_MAX_WIDTH,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [ADDR_W-1:0]           rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [ADDR_W-1:0]           wr_addr_i,
  input  logic [ldsm_pkg::LUMA_W-1:0] wr_lo_i,
  output logic [ldsm_pkg::LUMA_W-1:0] up2_o,
  output logic [ldsm_pkg::LUMA_W-1:0] up1_o
);
  import ldsm_pkg::*;

  logic [2*LUMA_W-1:0] mem_q [DEPTH];
  logic [2*LUMA_W-1:0] rd_q;
  logic [2*LUMA_W-1:0] fwd_data_q;
  logic                fwd_q;
  logic [2*LUMA_W-1:0] word;
  logic [2*LUMA_W-1:0] wr_word;

  assign word    = fwd_q ? fwd_data_q : rd_q;
  assign up2_o   = word[2*LUMA_W-1:LUMA_W];
  assign up1_o   = word[LUMA_W-1:0];
  assign wr_word = {up1_o, wr_lo_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_word;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_word;
    end
  end

  // a write landing on the column being read this cycle bypasses the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

endmodule

// File: rtl/core/ldsm_dev_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldsm_dev_test
// Squares the window statistics and compares 81*y*y + s*s against 9*s2 to
// decide the shadow bit.
// ----------------------------------------------------------------------------
module ldsm_dev_test (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ldsm_pkg::ldsm_stat_t stat_i,
  output logic                 valid_o,
  output logic                 shadow_o,
  output logic                 frame_end_o
);
  import ldsm_pkg::*;

  logic             valid_q;
  logic [CMP_W-1:0] ss_q;
  logic [CMP_W-1:0] yy_q;
  logic [CMP_W-1:0] sq9_q;
  logic             below_q;
  logic             fe_q;
  logic [CMP_W-1:0] y81;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ss_q    <= CMP_W'(stat_i.sum) * CMP_W'(stat_i.sum);
      yy_q    <= CMP_W'(16'(stat_i.center) * 16'(stat_i.center));
      sq9_q   <= (CMP_W'(stat_i.sq_sum) << 3) + CMP_W'(stat_i.sq_sum);
      below_q <= stat_i.below_limit;
      fe_q    <= stat_i.frame_end;
    end
  end

  assign y81         = (yy_q << 6) + (yy_q << 4) + yy_q;
  assign valid_o     = valid_q;
  assign shadow_o    = below_q || ((y81 + ss_q) < sq9_q);
  assign frame_end_o = fe_q;

endmodule

// File: rtl/core/local_deviation_shadow_mask_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_deviation_shadow_mask_unit
// Marks raster luma pixels as shadow by a global limit or the standard
// deviation of their 3x3 neighborhood.
//
// pix_i takes one item per pixel in raster order; after the frame's last
// pixel the source sends frame_width+1 flush items. The mask bit of pixel k
// is caused by item k+frame_width+1; frame_end marks the frame's last pixel.
// Throughput is one item per cycle while the result queue is not full, set
// by the line store, which does one read and one write per cycle, and the
// window cell chain shifting once per item. cfg_i takes register writes at
// any time (ready is always high); write only between items. Reset clears
// the counters and the window and loads the default registers; the line
// store is not cleared, its unwritten entries only reach masked window
// positions. A two-entry queue holds the results: when it is full,
// pix_i.ready drops and the pipeline holds.
// ----------------------------------------------------------------------------
module local_deviation_shadow_mask_unit #(
  parameter int unsigned MAX_WIDTH  = ldsm_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = ldsm_pkg::DEF_MAX_HEIGHT
) (
  input logic         clk_i,
  input logic         rst_ni,
  ldsm_cfg_if.sink    cfg_i,
  ldsm_pix_if.sink    pix_i,
  ldsm_res_if.source  res_o
);
  import ldsm_pkg::*;

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned CNT_W  = $clog2((MAX_HEIGHT + 2) * MAX_WIDTH + 1);
  localparam int unsigned AREA_W = WID_W + HGT_W;

  typedef struct packed {
    logic emit;
    logic top;
    logic bot;
    logic left;
    logic right;
  } ldsm_ctl_t;

  // configuration
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [WID_W-1:0]   w_eff;
  logic [HGT_W-1:0]   h_eff;
  logic [AREA_W-1:0]  area_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
      limit_q  <= RST_GLOBAL_LIMIT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FRAME_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        REG_GLOBAL_LIMIT: limit_q  <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] fw32;
  logic [31:0] fh32;
  assign fw32  = 32'(width_q);
  assign fh32  = 32'(height_q);
  assign w_eff = WID_W'((fw32 == 0) ? 32'd1 : (fw32 > MAX_WIDTH) ? 32'(MAX_WIDTH) : fw32);
  assign h_eff = HGT_W'((fh32 == 0) ? 32'd1 : (fh32 > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : fh32);

  always_ff @(posedge clk_i) begin
    area_q <= AREA_W'(w_eff) * AREA_W'(h_eff);
  end

  // pipeline enable: holds while the result queue is full
  logic [1:0] count_q;
  logic       en;
  logic       accept;

  assign en          = (count_q != 2'd2);
  assign pix_i.ready = en;
  assign accept      = pix_i.valid && en;

  // position counters and per-item control
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       c32, r32, w32, h32, orow32, ocol32;
  logic              has_out;
  logic [LUMA_W-1:0] x0;
  ldsm_ctl_t         ctl0;

  assign c32     = 32'(col_q);
  assign r32     = 32'(row_q);
  assign w32     = 32'(w_eff);
  assign h32     = 32'(h_eff);
  assign x0      = (!pix_i.flush && (r32 < h32)) ? pix_i.luma : '0;
  assign has_out = (r32 >= 32'd2) || ((r32 == 32'd1) && (c32 != 32'd0));
  assign orow32  = (c32 == 32'd0) ? r32 - 32'd2 : r32 - 32'd1;
  assign ocol32  = (c32 == 32'd0) ? w32 - 32'd1 : c32 - 32'd1;

  assign ctl0.emit  = has_out && (orow32 < h32);
  assign ctl0.top   = (orow32 != 32'd0);
  assign ctl0.bot   = ((orow32 + 32'd1) < h32);
  assign ctl0.left  = (ocol32 != 32'd0);
  assign ctl0.right = ((ocol32 + 32'd1) < w32);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q + {{(CNT_W-1){1'b0}}, ctl0.emit};
    if (r32 >= h32 + 32'd1) begin
      col_d = '0;
      row_d = '0;
      cnt_d = '0;
    end else if (c32 + 32'd1 >= w32) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
    end
  end

  // stage 1: line store data arrives
  logic              v1_q;
  logic [LUMA_W-1:0] x1_q;
  logic [COL_W-1:0]  addr1_q;
  ldsm_ctl_t         ctl1_q;
  logic [CNT_W-1:0]  cnt1_q;
  logic [LUMA_W-1:0] up2, up1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= x0;
      addr1_q <= col_q;
      ctl1_q  <= ctl0;
      cnt1_q  <= cnt_q;
    end
  end

  ldsm_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (en && v1_q),
    .wr_addr_i (addr1_q),
    .wr_lo_i   (x1_q),
    .up2_o     (up2),
    .up1_o     (up1)
  );

  // stage 2: window cells hold the shifted neighborhood
  logic      v2_q;
  ldsm_ctl_t ctl2_q;
  logic      fe2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl2_q <= ctl1_q;
      fe2_q  <= ((32'(cnt1_q) + 32'd1) == 32'(area_q));
    end
  end

  logic [2:0][2:0][LUMA_W-1:0] col;
  logic [2:0][SUM_W-1:0]       sum;
  logic [2:0][SQ_W-1:0]        sq;
  logic [2:0]                  row_en;
  logic [2:0]                  col_en;
  logic [2:0][LUMA_W-1:0]      new_col;

  assign new_col = {x1_q, up1, up2};
  assign row_en  = {ctl2_q.bot, 1'b1, ctl2_q.top};
  assign col_en  = {ctl2_q.right, 1'b1, ctl2_q.left};

  // cell 0 is the oldest column, cell 2 takes the new one
  for (genvar g = 0; g < 3; g++) begin : g_cell
    ldsm_col_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (en && v1_q),
      .col_i    ((g == 2) ? new_col : col[(g == 2) ? 2 : g + 1]),
      .col_o    (col[g]),
      .row_en_i (row_en),
      .col_en_i (col_en[g]),
      .sum_i    ((g == 0) ? '0 : sum[(g == 0) ? 0 : g - 1]),
      .sq_i     ((g == 0) ? '0 : sq[(g == 0) ? 0 : g - 1]),
      .sum_o    (sum[g]),
      .sq_o     (sq[g])
    );
  end

  // stage 3: window statistics
  logic       v3_q;
  ldsm_stat_t stat3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q && ctl2_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stat3_q.sum         <= sum[2];
      stat3_q.sq_sum      <= sq[2];
      stat3_q.center      <= col[1][1];
      stat3_q.below_limit <= ({1'b0, col[1][1]} < limit_q);
      stat3_q.frame_end   <= fe2_q;
    end
  end

  // stage 4: deviation compare
  logic v4;
  logic shadow4;
  logic fe4;

  ldsm_dev_test u_dev_test (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v3_q),
    .stat_i      (stat3_q),
    .valid_o     (v4),
    .shadow_o    (shadow4),
    .frame_end_o (fe4)
  );

  // two-entry result queue
  logic [1:0] shadow_q;
  logic [1:0] fe_q;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic       push;
  logic       pop;

  assign push = en && v4;
  assign pop  = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      shadow_q[wr_ptr_q] <= shadow4;
      fe_q[wr_ptr_q]     <= fe4;
    end
  end

  assign res_o.valid     = (count_q != 2'd0);
  assign res_o.shadow    = shadow_q[rd_ptr_q];
  assign res_o.frame_end = fe_q[rd_ptr_q];

endmodule

// File: dv/tb_local_deviation_shadow_mask_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_deviation_shadow_mask_unit
// Streams raster frames of luma pixels, each followed by its padding items,
// into the shadow mask block. A behavioral copy of the line stores, the 3x3
// window and the frame counters predicts the mask bit and frame_end of each
// result but two typed in the short directed table that opens the run. Random
// frames vary size, limit and content; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_local_deviation_shadow_mask_unit;
  import ldsm_pkg::*;

  localparam int unsigned MAX_W          = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H          = DEF_MAX_HEIGHT;
  localparam int          TOTAL_ITEMS    = 1700;
  localparam int          IDLE_PAUSE     = 8;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          DIR_ROWS       = 25;

  typedef enum logic [1:0] {
    ROW_PIXEL, ROW_SET_WIDTH, ROW_SET_HEIGHT, ROW_SET_LIMIT
  } row_op_t;

  typedef enum logic [1:0] {
    LUMA_UNIFORM, LUMA_FLAT, LUMA_SPOTS, LUMA_EXTREME
  } luma_style_t;

  typedef struct packed {
    row_op_t               op;
    logic [CFG_DATA_W-1:0] data;
    logic                  flush;
    logic                  has_exp;
    logic                  exp_shadow;
    logic                  exp_frame_end;
  } stim_row_t;

  typedef struct packed {
    logic shadow;
    logic frame_end;
  } mask_res_t;

  // two 1x1 frames with typed results, then a black and white 3x3 frame whose center is flushed
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_SET_WIDTH,  11'd1,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SET_HEIGHT, 11'd1,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SET_LIMIT,  11'd256, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd255, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd77,  1'b0, 1'b1, 1'b1, 1'b1},
    '{ROW_SET_LIMIT,  11'd0,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b1, 1'b1, 1'b0, 1'b1},
    '{ROW_SET_WIDTH,  11'd3,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_SET_HEIGHT, 11'd3,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd255, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd255, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd200, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd255, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd255, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd255, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd123, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd0,   1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_PIXEL,      11'd255, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  ldsm_cfg_if cfg_if ();
  ldsm_pix_if pix_if ();
  ldsm_res_if res_if ();

  local_deviation_shadow_mask_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  // typed results of directed rows travel with the item
  logic hint_on;
  logic hint_sh;
  logic hint_fe;

  bit pix_burst;
  bit res_burst;

  // predictor state
  logic [DIM_W-1:0]   px_width  = RST_FRAME_WIDTH;
  logic [DIM_W-1:0]   px_height = RST_FRAME_HEIGHT;
  logic [LIMIT_W-1:0] px_limit  = RST_GLOBAL_LIMIT;
  logic [7:0]  lstore [2*MAX_W] = '{default: 8'h00};
  logic [7:0]  win [9]          = '{default: 8'h00};
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned emitted;

  mask_res_t mask_q [$];

  int n_err;
  int n_results;
  int n_shadow;
  int n_frames_done;
  int n_cfg;
  int sent_items;
  int quiet_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // one raster item through the line stores and window; returns 1 on a result
  function automatic bit mask_step(input logic [7:0] luma_in, input logic pad_in,
                                   output logic sh, output logic fe);
    int unsigned w, h, c, r, ci, orow, ocol;
    logic [7:0] x, up2, up1;
    longint unsigned s, s2, y, v;
    int nr, nc;
    bit got;
    w = (px_width == 0) ? 1 : ((px_width > MAX_W) ? MAX_W : px_width);
    h = (px_height == 0) ? 1 : ((px_height > MAX_H) ? MAX_H : px_height);
    c = col_pos;
    r = row_pos;
    x = (pad_in || r >= h) ? 8'd0 : luma_in;
    ci = (c < MAX_W) ? c : MAX_W - 1;
    up2 = lstore[ci];
    up1 = lstore[MAX_W + ci];
    lstore[ci] = up1;
    lstore[MAX_W + ci] = x;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = x;
    got = 1'b0;
    sh = 1'b0;
    fe = 1'b0;
    if (r >= 2 || (r == 1 && c >= 1)) begin
      orow = (c == 0) ? r - 2 : r - 1;
      ocol = (c == 0) ? w - 1 : c - 1;
      if (orow < h) begin
        s = 0;
        s2 = 0;
        y = win[4];
        for (int dr = 0; dr < 3; dr++) begin
          for (int dc = 0; dc < 3; dc++) begin
            nr = int'(orow) + dr - 1;
            nc = int'(ocol) + dc - 1;
            // neighbors outside the frame count as zero
            if (nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)) begin
              v = win[dr*3+dc];
              s += v;
              s2 += v * v;
            end
          end
        end
        sh = (y < px_limit) || (81 * y * y + s * s < 9 * s2);
        fe = (emitted + 1 == w * h);
        emitted++;
        got = 1'b1;
      end
    end
    if (r >= h + 1) begin
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
    end else if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    return got;
  endfunction

  // result check, register tracking and prediction, all on the same edge
  always @(posedge clk_i) begin
    mask_res_t want;
    logic p_sh, p_fe;
    bit made;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        n_results++;
        if (res_if.shadow === 1'b1) n_shadow++;
        if (res_if.frame_end === 1'b1) n_frames_done++;
        if (mask_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("%0t: mask result with no pixel item waiting", $time);
        end else begin
          want = mask_q.pop_front();
          if (res_if.shadow !== want.shadow || res_if.frame_end !== want.frame_end) begin
            n_err++;
            if (n_err <= 10)
              $display("%0t: result %0d: expected shadow=%0b frame_end=%0b, got %0b %0b",
                       $time, n_results, want.shadow, want.frame_end,
                       res_if.shadow, res_if.frame_end);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        n_cfg++;
        case (cfg_if.index)
          REG_FRAME_WIDTH:  px_width = cfg_if.data;
          REG_FRAME_HEIGHT: px_height = cfg_if.data;
          REG_GLOBAL_LIMIT: px_limit = cfg_if.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) begin
        made = mask_step(pix_if.luma, pix_if.flush, p_sh, p_fe);
        if (hint_on) begin
          made = 1'b1;
          p_sh = hint_sh;
          p_fe = hint_fe;
        end
        if (made) mask_q.insert(mask_q.size(), mask_res_t'{shadow: p_sh, frame_end: p_fe});
      end
    end
    if ((res_if.valid && res_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (pix_if.valid && pix_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // result side: random stall before each item, none in burst phases
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = res_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_pixel(input logic [7:0] luma, input logic pad,
                            input logic chk, input logic chk_sh, input logic chk_fe);
    int gap;
    gap = pix_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.luma  <= luma;
    pix_if.flush <= pad;
    hint_on <= chk;
    hint_sh <= chk_sh;
    hint_fe <= chk_fe;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    sent_items++;
  endtask

  // leaves valid high so that back-to-back writes need no second assignment
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
  endtask

  task automatic settle_pipeline();
    while (mask_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w_raw,
                           input logic [CFG_DATA_W-1:0] h_raw,
                           input logic [CFG_DATA_W-1:0] lim_raw, input int frames);
    int w, h;
    luma_style_t style;
    logic [7:0] base, lv;
    w = (w_raw == 0) ? 1 : ((w_raw > MAX_W) ? MAX_W : w_raw);
    h = (h_raw == 0) ? 1 : ((h_raw > MAX_H) ? MAX_H : h_raw);
    settle_pipeline();
    pix_burst = ($urandom_range(0, 3) == 0);
    res_burst = ($urandom_range(0, 3) == 0);
    write_reg(REG_FRAME_WIDTH, w_raw);
    write_reg(REG_FRAME_HEIGHT, h_raw);
    write_reg(REG_GLOBAL_LIMIT, lim_raw);
    cfg_if.valid <= 1'b0;
    for (int f = 0; f < frames; f++) begin
      style = luma_style_t'($urandom_range(0, 3));
      base = 8'($urandom);
      for (int k = 0; k < w * h; k++) begin
        case (style)
          LUMA_FLAT:    lv = base + 8'($urandom_range(0, 3));
          LUMA_SPOTS:   lv = ($urandom_range(0, 7) == 0) ? 8'($urandom) : base;
          LUMA_EXTREME: lv = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
          default:      lv = 8'($urandom);
        endcase
        // an odd flush inside the frame reads as a black pixel
        push_pixel(lv, $urandom_range(0, 31) == 0, 1'b0, 1'b0, 1'b0);
      end
      for (int k = 0; k <= w; k++)
        push_pixel(8'($urandom), $urandom_range(0, 7) != 0, 1'b0, 1'b0, 1'b0);
    end
    pix_if.valid <= 1'b0;
  endtask

  initial begin
    stim_row_t row;
    bit cfg_open;
    logic [CFG_DATA_W-1:0] w_raw, h_raw, lim_raw;
    rst_ni       <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_FRAME_WIDTH;
    cfg_if.data  <= '0;
    pix_if.valid <= 1'b0;
    pix_if.luma  <= '0;
    pix_if.flush <= 1'b0;
    hint_on <= 1'b0;
    hint_sh <= 1'b0;
    hint_fe <= 1'b0;
    pix_burst = 1'b0;
    res_burst = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_open = 1'b1;
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.op == ROW_PIXEL) begin
        if (cfg_open) begin
          cfg_if.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        push_pixel(row.data[7:0], row.flush, row.has_exp, row.exp_shadow, row.exp_frame_end);
      end else begin
        if (!cfg_open) begin
          pix_if.valid <= 1'b0;
          settle_pipeline();
          cfg_open = 1'b1;
        end
        case (row.op)
          ROW_SET_WIDTH:  write_reg(REG_FRAME_WIDTH, row.data);
          ROW_SET_HEIGHT: write_reg(REG_FRAME_HEIGHT, row.data);
          default:        write_reg(REG_GLOBAL_LIMIT, row.data);
        endcase
      end
    end
    pix_if.valid <= 1'b0;

    // extreme sizes: tallest column clamped to the maximum, zero dims acting as one
    run_phase(11'd1, 11'h7FF, 11'd0, 1);
    run_phase(11'd0, 11'd0, 11'd0, 2);

    while (sent_items < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_raw = 11'($urandom_range(13, 40));
        1:       w_raw = 11'd0;
        default: w_raw = 11'($urandom_range(1, 12));
      endcase
      h_raw = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
      case ($urandom_range(0, 5))
        0, 1:    lim_raw = 11'd0;
        2:       lim_raw = 11'd256;
        3:       lim_raw = 11'($urandom_range(0, 2047));
        default: lim_raw = 11'($urandom_range(0, 80));
      endcase
      run_phase(w_raw, h_raw, lim_raw, $urandom_range(1, 3));
    end

    settle_pipeline();
    $display("checked %0d mask results (%0d shadow) over %0d frames from %0d pixel items",
             n_results, n_shadow, n_frames_done, sent_items);
    $display("%0d register writes, frames from 1x1 up to 1024 rows tall", n_cfg);
    if (n_err == 0 && mask_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
